>>> hdl/b2da_pkg.sv
// Package for the binary to decimal ASCII converter.
// Holds shared widths, codes, the queued item type and the back-end state type.
// No dependencies.
package b2da_pkg;

  localparam int VALUE_BITS = 32;
  localparam int IN_BITS    = 32;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_BITS   = 4 * NUM_DIGITS;
  localparam int CNT_W      = 4;
  localparam int STEP_W     = $clog2(VALUE_BITS);
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic       OP_RAW     = 1'b0;
  localparam logic       OP_DEC     = 1'b1;
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;

  typedef struct packed {
    logic                  is_dec;
    logic [VALUE_BITS-1:0] value;
    logic [7:0]            raw_char;
  } b2da_item_t;

  typedef struct packed {
    logic valid;
    logic full;
  } b2da_qstat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_SIZE,
    ST_EMIT
  } b2da_state_e;

endpackage

>>> hdl/b2da_queue.sv
// Short item queue between the front end and the conversion back end.
// Depends on b2da_pkg.
module b2da_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  b2da_pkg::b2da_item_t item_i,
  input  logic                 pop_i,
  output b2da_pkg::b2da_item_t item_o,
  output b2da_pkg::b2da_qstat_t stat_o
);
  import b2da_pkg::*;

  b2da_item_t        mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  assign item_o       = mem_q[rd_q];
  assign stat_o.valid = (cnt_q != '0);
  assign stat_o.full  = (cnt_q == QCNT_W'(QDEPTH));

endmodule

>>> hdl/b2da_back.sv
// Conversion back end: shift-add-3 sequencer, digit sizing and character emitter.
// Depends on b2da_pkg.
module b2da_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  b2da_pkg::b2da_item_t  item_i,
  input  b2da_pkg::b2da_qstat_t qstat_i,
  output logic                  pop_o,
  output logic                  strobe_o,
  output logic [7:0]            ascii_char_o,
  output logic [3:0]            char_count_o,
  output logic                  last_o
);
  import b2da_pkg::*;

  b2da_state_e           state_q, state_d;
  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [BCD_BITS-1:0]   bcd_q, bcd_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [CNT_W-1:0]      idx_q, idx_d;
  logic                  raw_q, raw_d;
  logic [7:0]            char_q, char_d;
  logic [BCD_BITS-1:0]   bcd_adj;
  logic [CNT_W-1:0]      size_calc;

  always_comb begin
    for (int d = 0; d < NUM_DIGITS; d++) begin
      bcd_adj[d*4 +: 4] = (bcd_q[d*4 +: 4] >= 4'd5) ? bcd_q[d*4 +: 4] + 4'd3
                                                     : bcd_q[d*4 +: 4];
    end
  end

  always_comb begin
    size_calc = CNT_W'(1);
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd_q[d*4 +: 4] != 4'd0) begin
        size_calc = CNT_W'(d + 1);
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    bin_d    = bin_q;
    bcd_d    = bcd_q;
    step_d   = step_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    raw_d    = raw_q;
    char_d   = char_q;
    pop_o    = 1'b0;
    strobe_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (qstat_i.valid) begin
          pop_o  = 1'b1;
          raw_d  = !item_i.is_dec;
          char_d = item_i.raw_char;
          bin_d  = item_i.value;
          bcd_d  = '0;
          step_d = '0;
          cnt_d  = CNT_W'(1);
          idx_d  = '0;
          state_d = item_i.is_dec ? ST_DABBLE : ST_EMIT;
        end
      end
      ST_DABBLE: begin
        {bcd_d, bin_d} = {bcd_adj, bin_q} << 1;
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(VALUE_BITS - 1)) begin
          state_d = ST_SIZE;
        end
      end
      ST_SIZE: begin
        cnt_d   = size_calc;
        idx_d   = size_calc - 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        strobe_o = 1'b1;
        idx_d    = idx_q - 1'b1;
        if (idx_q == '0) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    step_q <= step_d;
    cnt_q  <= cnt_d;
    idx_q  <= idx_d;
    raw_q  <= raw_d;
    char_q <= char_d;
  end

  assign ascii_char_o = raw_q ? char_q : ASCII_ZERO + {4'd0, bcd_q[idx_q*4 +: 4]};
  assign char_count_o = cnt_q;
  assign last_o       = strobe_o && (idx_q == '0);

  a_gap_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_o |=> !strobe_o)
    else $error("beat directly after last");

  a_run_continues : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |=> strobe_o && $stable(char_count_o))
    else $error("run broken or count changed");

  a_digit_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !raw_q |-> ascii_char_o >= ASCII_ZERO && ascii_char_o <= ASCII_NINE)
    else $error("converted character is not a digit");

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> char_count_o != '0 && char_count_o <= CNT_W'(NUM_DIGITS))
    else $error("character count out of range");

endmodule

>>> hdl/binary_to_decimal_ascii.sv
// Binary to decimal ASCII converter, top level.
// Uses b2da_pkg, b2da_queue and b2da_back.
//
// Input: an item (opcode_i, value_i) is taken at a clock edge with start
// high and busy low. Opcode 0 passes the low byte of value_i as one
// character; opcode 1 emits the unsigned value as decimal ASCII digits,
// most significant first, no leading zeros, zero gives a single '0'.
// Output: each character is on ascii_char_o for one cycle with strobe_o
// high, together with char_count_o (characters in the run) and last_o.
// An idle back end picks an item up in the cycle after it is taken.
// A raw character is then driven for one cycle. A conversion runs a pickup,
// the serial shift-add-3 loop over every value bit, a sizing step, then
// one character per cycle. The back end takes no new item until it has
// emitted the last character of the current one.
// A two-entry queue holds items while the back end works; busy is high
// while it is full.
// Reset empties the queue and returns the back end to idle.
// The receiver cannot stall: every strobe beat must be taken.
module binary_to_decimal_ascii (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        opcode_i,
  input  logic [31:0] value_i,
  output logic        strobe_o,
  output logic [7:0]  ascii_char_o,
  output logic [3:0]  char_count_o,
  output logic        last_o
);
  import b2da_pkg::*;

  b2da_item_t  in_item, q_item;
  b2da_qstat_t q_stat;
  logic        push, pop;

  assign in_item.is_dec   = (opcode_i == OP_DEC);
  assign in_item.value    = VALUE_BITS'(value_i);
  assign in_item.raw_char = value_i[7:0];

  assign busy = q_stat.full;
  assign push = start && !q_stat.full;

  b2da_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (in_item),
    .pop_i  (pop),
    .item_o (q_item),
    .stat_o (q_stat)
  );

  b2da_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (q_item),
    .qstat_i      (q_stat),
    .pop_o        (pop),
    .strobe_o     (strobe_o),
    .ascii_char_o (ascii_char_o),
    .char_count_o (char_count_o),
    .last_o       (last_o)
  );

endmodule
